>>> hdl/abac_pkg.sv
// ----------------------------------------------------------------------------
// ARM build attribute classifier package
// Shared constants, codes and tables for the build attribute classifier.
// ----------------------------------------------------------------------------
package abac_pkg;

   // Default width of the byte position counter and the subsection ends.
   localparam int POSITION_BITS_DEFAULT = 32;

   // Width of a gathered 4-byte length field.
   localparam int LENGTH_BITS = 32;

   // Architecture codes reported on the last byte of a section.
   localparam logic [1:0] ARCH_NONE      = 2'd0;
   localparam logic [1:0] ARCH_V4_SOFT   = 2'd1;
   localparam logic [1:0] ARCH_V6_HARD   = 2'd2;
   localparam logic [1:0] ARCH_V7_HARD   = 2'd3;

   // Section format version byte ('A') and the file-scope sub-block code.
   localparam logic [7:0] VERSION_BYTE     = 8'h41;
   localparam logic [7:0] FILE_SCOPE_BYTE  = 8'h01;

   // Number of characters in the vendor name that is parsed.
   localparam logic [2:0] VENDOR_LENGTH  = 3'd5;

   // Attribute tags of interest.
   localparam logic [31:0] TAG_CONFORMANCE  = 32'd4;
   localparam logic [31:0] TAG_CPU_NAME     = 32'd5;
   localparam logic [31:0] TAG_ALSO_COMPAT  = 32'd67;
   localparam logic [31:0] TAG_PROC_ARCH    = 32'd6;
   localparam logic [31:0] TAG_VFP_ARGS     = 32'd28;

   // Architecture tag values that are accepted.
   localparam logic [31:0] PROC_ARCH_V4     = 32'd1;
   localparam logic [31:0] PROC_ARCH_V6     = 32'd6;
   localparam logic [31:0] PROC_ARCH_V7     = 32'd10;

   // VFP argument passing value that marks hard float.
   localparam logic [31:0] VFP_ARGS_HARD    = 32'd1;

   // Characters of the vendor name "aeabi", by position.
   function automatic logic [7:0] vendor_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h61;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h61;
         3'd3:    c = 8'h62;
         3'd4:    c = 8'h69;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/abac_parser.sv
// ----------------------------------------------------------------------------
// ARM build attribute parser
// Walks the section one byte per step and keeps the parse state, the seen
// architecture and the hard float flag; gives the code for a closing byte.
// ----------------------------------------------------------------------------
module abac_parser #(
   parameter int POSITION_BITS = abac_pkg::POSITION_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       big_endian,
   output logic [1:0] arch_code
);
   import abac_pkg::*;

   localparam int SUM_BITS = LENGTH_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   typedef enum logic [3:0] {
      PH_VERSION,
      PH_SUB_LEN,
      PH_VENDOR,
      PH_FILE_TAG,
      PH_ATTR_LEN,
      PH_ATTR_TAG,
      PH_STRING,
      PH_ATTR_VAL,
      PH_SKIP,
      PH_FAILED
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_PROC_ARCH,
      KIND_VFP_ARGS
   } tag_kind_type;

   phase_type                phase_ff, phase_in, phase_nx;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] sub_end_ff, sub_end_in, sub_end_nx;
   logic [POSITION_BITS-1:0] attr_end_ff, attr_end_in, attr_end_nx;
   logic [LENGTH_BITS-1:0]   gather_ff, gather_in, gather_nx;
   logic [2:0]               count_ff, count_in, count_nx;
   logic [31:0]              uleb_ff, uleb_in, uleb_nx;
   logic [5:0]               shift_ff, shift_in, shift_nx;
   tag_kind_type             kind_ff, kind_in, kind_nx;
   logic [1:0]               arch_ff, arch_in, arch_nx;
   logic                     hf_ff, hf_in, hf_nx;
   logic                     failed_ff, failed_in, failed_nx;

   logic [POSITION_BITS-1:0] next_pos;
   logic [LENGTH_BITS-1:0]   gather_new;
   logic [2:0]               count_plus;
   logic [SUM_BITS-1:0]      sub_sum;
   logic [POSITION_BITS-1:0] sub_sat;
   logic [SUM_BITS-1:0]      attr_sum;
   logic [31:0]              uleb_new;
   logic                     uleb_done;
   logic [6:0]               shift_sum;
   logic [5:0]               shift_inc;
   tag_kind_type             kind_new;
   logic                     string_tag;
   tag_kind_type             pair_kind;
   logic [31:0]              pair_value;
   logic                     pair_fail;
   logic                     pair_set_arch;
   logic [1:0]               pair_arch;
   logic                     pair_set_hf;
   logic                     finish_skip;
   logic                     attr_more;

   function automatic tag_kind_type kind_of(input logic [31:0] tag);
      tag_kind_type k;
      if (tag == TAG_PROC_ARCH) begin
         k = KIND_PROC_ARCH;
      end else if (tag == TAG_VFP_ARGS) begin
         k = KIND_VFP_ARGS;
      end else begin
         k = KIND_OTHER;
      end
      return k;
   endfunction

   // Byte-level datapath shared by all phases.
   always_comb begin
      next_pos = pos_ff + POSITION_BITS'(1);
      if (big_endian) begin
         gather_new = {gather_ff[LENGTH_BITS-9:0], data_byte};
      end else begin
         gather_new = gather_ff | (LENGTH_BITS'(data_byte) << {count_ff[1:0], 3'b000});
      end
      count_plus = count_ff + 3'd1;
      sub_sum    = SUM_BITS'(sub_end_ff) + SUM_BITS'(gather_new);
      sub_sat    = (sub_sum > SUM_BITS'(POS_MAX)) ? POS_MAX : POSITION_BITS'(sub_sum);
      attr_sum   = SUM_BITS'(attr_end_ff) + SUM_BITS'(gather_new);

      // Bits shifted past bit 31 are dropped.
      uleb_new   = uleb_ff;
      if (shift_ff < 6'd32) begin
         uleb_new = uleb_ff | ({25'd0, data_byte[6:0]} << shift_ff[4:0]);
      end
      uleb_done  = !data_byte[7] || (next_pos >= attr_end_ff);
      shift_sum  = {1'b0, shift_ff} + 7'd7;
      shift_inc  = (shift_sum > 7'd63) ? 6'd63 : shift_sum[5:0];
      kind_new   = kind_of(uleb_new);
      string_tag = (uleb_new == TAG_CONFORMANCE) || (uleb_new == TAG_CPU_NAME) ||
                   (uleb_new == TAG_ALSO_COMPAT);

      // A tag cut by the end of the block pairs with the value zero.
      if (phase_ff == PH_ATTR_VAL) begin
         pair_kind  = kind_ff;
         pair_value = uleb_new;
      end else begin
         pair_kind  = kind_new;
         pair_value = 32'd0;
      end
      pair_fail     = 1'b0;
      pair_set_arch = 1'b0;
      pair_arch     = ARCH_NONE;
      pair_set_hf   = 1'b0;
      if (pair_kind == KIND_PROC_ARCH) begin
         pair_set_arch = 1'b1;
         if (pair_value == PROC_ARCH_V4) begin
            pair_arch = ARCH_V4_SOFT;
         end else if (pair_value == PROC_ARCH_V6) begin
            pair_arch = ARCH_V6_HARD;
         end else if (pair_value == PROC_ARCH_V7) begin
            pair_arch = ARCH_V7_HARD;
         end else begin
            pair_fail = 1'b1;
         end
      end else if (pair_kind == KIND_VFP_ARGS) begin
         pair_set_hf = (pair_value == VFP_ARGS_HARD);
      end

      finish_skip = next_pos < sub_end_ff;
      attr_more   = next_pos < attr_end_ff;
   end

   // Phase sequencing for one accepted byte.
   always_comb begin
      phase_nx    = phase_ff;
      sub_end_nx  = sub_end_ff;
      attr_end_nx = attr_end_ff;
      gather_nx   = gather_ff;
      count_nx    = count_ff;
      uleb_nx     = uleb_ff;
      shift_nx    = shift_ff;
      kind_nx     = kind_ff;
      arch_nx     = arch_ff;
      hf_nx       = hf_ff;
      failed_nx   = failed_ff;

      unique case (phase_ff)
         PH_VERSION: begin
            if (data_byte == VERSION_BYTE) begin
               phase_nx  = PH_SUB_LEN;
               gather_nx = '0;
               count_nx  = '0;
            end else begin
               failed_nx = 1'b1;
               phase_nx  = PH_FAILED;
            end
         end
         PH_SUB_LEN: begin
            if (count_ff == 3'd0) begin
               sub_end_nx = pos_ff;
            end
            gather_nx = gather_new;
            count_nx  = count_plus;
            if (count_plus >= 3'd4) begin
               sub_end_nx = sub_sat;
               phase_nx   = PH_VENDOR;
               count_nx   = '0;
            end
         end
         PH_VENDOR: begin
            if (count_ff < VENDOR_LENGTH) begin
               if (data_byte != vendor_char(count_ff)) begin
                  if (finish_skip) begin
                     phase_nx = PH_SKIP;
                  end else begin
                     phase_nx  = PH_SUB_LEN;
                     gather_nx = '0;
                     count_nx  = '0;
                  end
               end else begin
                  count_nx = count_plus;
               end
            end else begin
               phase_nx = PH_FILE_TAG;
            end
         end
         PH_FILE_TAG: begin
            if (data_byte != FILE_SCOPE_BYTE) begin
               if (finish_skip) begin
                  phase_nx = PH_SKIP;
               end else begin
                  phase_nx  = PH_SUB_LEN;
                  gather_nx = '0;
                  count_nx  = '0;
               end
            end else begin
               attr_end_nx = pos_ff;
               gather_nx   = '0;
               count_nx    = '0;
               phase_nx    = PH_ATTR_LEN;
            end
         end
         PH_ATTR_LEN: begin
            gather_nx = gather_new;
            count_nx  = count_plus;
            if (count_plus >= 3'd4) begin
               if (attr_sum > SUM_BITS'(sub_end_ff)) begin
                  failed_nx = 1'b1;
                  phase_nx  = PH_FAILED;
               end else begin
                  attr_end_nx = POSITION_BITS'(attr_sum);
                  if (SUM_BITS'(next_pos) < attr_sum) begin
                     phase_nx = PH_ATTR_TAG;
                     uleb_nx  = '0;
                     shift_nx = '0;
                  end else if (finish_skip) begin
                     phase_nx = PH_SKIP;
                  end else begin
                     phase_nx  = PH_SUB_LEN;
                     gather_nx = '0;
                     count_nx  = '0;
                  end
               end
            end
         end
         PH_ATTR_TAG, PH_ATTR_VAL: begin
            uleb_nx = uleb_new;
            if (!uleb_done) begin
               shift_nx = shift_inc;
            end else if (phase_ff == PH_ATTR_TAG && string_tag) begin
               kind_nx  = kind_new;
               phase_nx = PH_STRING;
            end else if (phase_ff == PH_ATTR_TAG && attr_more) begin
               kind_nx  = kind_new;
               phase_nx = PH_ATTR_VAL;
               uleb_nx  = '0;
               shift_nx = '0;
            end else begin
               if (phase_ff == PH_ATTR_TAG) begin
                  kind_nx = kind_new;
               end
               if (pair_fail) begin
                  failed_nx = 1'b1;
                  phase_nx  = PH_FAILED;
               end else begin
                  if (pair_set_arch) begin
                     arch_nx = pair_arch;
                  end
                  if (pair_set_hf) begin
                     hf_nx = 1'b1;
                  end
                  if (attr_more) begin
                     phase_nx = PH_ATTR_TAG;
                     uleb_nx  = '0;
                     shift_nx = '0;
                  end else if (finish_skip) begin
                     phase_nx = PH_SKIP;
                  end else begin
                     phase_nx  = PH_SUB_LEN;
                     gather_nx = '0;
                     count_nx  = '0;
                  end
               end
            end
         end
         PH_STRING: begin
            if (data_byte == 8'h00) begin
               if (next_pos > attr_end_ff) begin
                  failed_nx = 1'b1;
                  phase_nx  = PH_FAILED;
               end else if (attr_more) begin
                  phase_nx = PH_ATTR_TAG;
                  uleb_nx  = '0;
                  shift_nx = '0;
               end else if (finish_skip) begin
                  phase_nx = PH_SKIP;
               end else begin
                  phase_nx  = PH_SUB_LEN;
                  gather_nx = '0;
                  count_nx  = '0;
               end
            end
         end
         PH_SKIP: begin
            if (!finish_skip) begin
               phase_nx  = PH_SUB_LEN;
               gather_nx = '0;
               count_nx  = '0;
            end
         end
         PH_FAILED: begin
         end
         default: begin
         end
      endcase
   end

   // Code for a closing byte, from the state after that byte.
   always_comb begin
      if (failed_nx) begin
         arch_code = ARCH_NONE;
      end else if (arch_nx == ARCH_V4_SOFT && hf_nx) begin
         arch_code = ARCH_NONE;
      end else if ((arch_nx == ARCH_V6_HARD || arch_nx == ARCH_V7_HARD) && !hf_nx) begin
         arch_code = ARCH_NONE;
      end else begin
         arch_code = arch_nx;
      end
   end

   // Commit the step; a closing byte returns the parser to its reset state.
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      sub_end_in  = sub_end_ff;
      attr_end_in = attr_end_ff;
      gather_in   = gather_ff;
      count_in    = count_ff;
      uleb_in     = uleb_ff;
      shift_in    = shift_ff;
      kind_in     = kind_ff;
      arch_in     = arch_ff;
      hf_in       = hf_ff;
      failed_in   = failed_ff;
      if (step) begin
         if (last_byte) begin
            phase_in    = PH_VERSION;
            pos_in      = '0;
            sub_end_in  = '0;
            attr_end_in = '0;
            gather_in   = '0;
            count_in    = '0;
            uleb_in     = '0;
            shift_in    = '0;
            kind_in     = KIND_OTHER;
            arch_in     = ARCH_NONE;
            hf_in       = 1'b0;
            failed_in   = 1'b0;
         end else begin
            phase_in    = phase_nx;
            pos_in      = next_pos;
            sub_end_in  = sub_end_nx;
            attr_end_in = attr_end_nx;
            gather_in   = gather_nx;
            count_in    = count_nx;
            uleb_in     = uleb_nx;
            shift_in    = shift_nx;
            kind_in     = kind_nx;
            arch_in     = arch_nx;
            hf_in       = hf_nx;
            failed_in   = failed_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_VERSION;
         pos_ff      <= '0;
         sub_end_ff  <= '0;
         attr_end_ff <= '0;
         gather_ff   <= '0;
         count_ff    <= '0;
         uleb_ff     <= '0;
         shift_ff    <= '0;
         kind_ff     <= KIND_OTHER;
         arch_ff     <= ARCH_NONE;
         hf_ff       <= 1'b0;
         failed_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         sub_end_ff  <= sub_end_in;
         attr_end_ff <= attr_end_in;
         gather_ff   <= gather_in;
         count_ff    <= count_in;
         uleb_ff     <= uleb_in;
         shift_ff    <= shift_in;
         kind_ff     <= kind_in;
         arch_ff     <= arch_in;
         hf_ff       <= hf_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

>>> hdl/arm_build_attribute_classifier.sv
// ----------------------------------------------------------------------------
// ARM build attribute classifier
// Classifies an ARM build attributes section into an architecture code.
// ----------------------------------------------------------------------------
// Usage: the section contents enter on the req_ channel one byte per
// transaction, with req_last_byte set on the final byte. Every byte updates
// the parse state in the cycle it is accepted, so one byte is taken per
// cycle while req_ready is high. Only the transaction that carries the last
// byte produces a result: rsp_arch_code appears on the rsp_ channel in the
// cycle after that byte is accepted, and the parser is back at the start of
// a new section on the next cycle, so sections may follow each other without
// a gap. The single output register holds a result while the receiver
// stalls; req_ready stays high as long as that register is empty or is
// being emptied in the same cycle, and drops only while a result waits.
// The csr_ port writes the byte order of the length fields (1 means big
// endian) with no handshake; write it only between sections. Reset clears
// the parse state, the output register and the byte order (little endian).
// ----------------------------------------------------------------------------
module arm_build_attribute_classifier #(
   parameter int POSITION_BITS = abac_pkg::POSITION_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_arch_code,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import abac_pkg::*;

   logic       big_endian_ff, big_endian_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_code_ff, rsp_code_in;
   logic       req_accept;
   logic [1:0] parse_code;

   // A new byte is taken whenever the result register can accept a result.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   abac_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .big_endian (big_endian_ff),
      .arch_code  (parse_code)
   );

   always_comb begin
      big_endian_in = csr_write_enable ? csr_write_data : big_endian_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      if (req_accept && req_last_byte) begin
         // The closing byte of a section loads a fresh result.
         rsp_valid_in = 1'b1;
         rsp_code_in  = parse_code;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_arch_code = rsp_code_ff;

endmodule

>>> hdl/abac_checker.sv
// ----------------------------------------------------------------------------
// ARM build attribute classifier checker
// Port-level assertions on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module abac_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_arch_code
);

   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_arch_code))
      else $error("stalled result changed or dropped");

   // A closing byte always yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("closing byte gave no result");

   // Bytes that do not close a section give no result.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_last_byte) |=> !rsp_valid)
      else $error("result without a closing byte");

   // The input is never held off while the result register is empty.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind arm_build_attribute_classifier abac_checker u_abac_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_arch_code (rsp_arch_code)
);

>>> test/tb_arm_build_attribute_classifier.sv
// ----------------------------------------------------------------------------
// Testbench for the ARM build attribute classifier
// Feeds attribute sections byte by byte under both byte orders and checks
// every architecture code against a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-built sections whose outcome is
// obvious, then moves on to random sections. Most random sections are
// well-formed "aeabi" subsections with random attribute content, since only
// those reach the deep states of the parser; the rest are foreign vendors,
// other sub-block codes, broken lengths, truncated sections and plain noise.
// Both channels idle at random, the receiver holds off once for a long
// stretch so that the block stalls its input, and the byte order register
// is rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_arm_build_attribute_classifier;
   import abac_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transaction
   localparam int RSP_HOLD_CYCLES = 160;   // the long receiver hold-off
   localparam int PHASE_COUNT     = 4;
   localparam int PHASE_BYTES     = 200;   // bytes that reach the parser
   localparam int PHASE_SECTIONS  = 5;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_LIMIT     = 4000;

   // Positions wrap at the counter width; computed ends saturate to this.
   localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS_DEFAULT) - 64'd1;

   // The vendor name that selects the parsed subsection.
   localparam logic [39:0] AEABI_TEXT = "aeabi";

   // Parser states of the predictor.
   typedef enum logic [3:0] {
      ST_VERSION, ST_SUB_LEN, ST_VENDOR, ST_FILE_TAG, ST_ATTR_LEN,
      ST_ATTR_TAG, ST_STRING, ST_ATTR_VAL, ST_SKIP, ST_FAILED
   } walk_state_type;

   // One row of the directed table. Where known is set, the code on the
   // last byte is typed in; otherwise the predictor supplies it.
   typedef struct packed {
      logic [7:0] data;
      logic       last_flag;
      logic       known;
      logic [1:0] code;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [23] = '{
      // Bad version bytes at both extremes, then a section of just 'A'.
      '{8'hFF, 1'b1, 1'b1, ARCH_NONE},
      '{8'h00, 1'b1, 1'b1, ARCH_NONE},
      '{VERSION_BYTE, 1'b1, 1'b1, ARCH_NONE},
      // A complete little-endian section: armv7 with hard float arguments.
      '{VERSION_BYTE, 1'b0, 1'b0, ARCH_NONE},
      '{8'h13, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{8'h61, 1'b0, 1'b0, ARCH_NONE},
      '{8'h65, 1'b0, 1'b0, ARCH_NONE},
      '{8'h61, 1'b0, 1'b0, ARCH_NONE},
      '{8'h62, 1'b0, 1'b0, ARCH_NONE},
      '{8'h69, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{FILE_SCOPE_BYTE, 1'b0, 1'b0, ARCH_NONE},
      '{8'h09, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{8'h00, 1'b0, 1'b0, ARCH_NONE},
      '{TAG_PROC_ARCH[7:0], 1'b0, 1'b0, ARCH_NONE},
      '{PROC_ARCH_V7[7:0], 1'b0, 1'b0, ARCH_NONE},
      '{TAG_VFP_ARGS[7:0], 1'b0, 1'b0, ARCH_NONE},
      '{VFP_ARGS_HARD[7:0], 1'b1, 1'b1, ARCH_V7_HARD}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_arch_code;
   logic       csr_write_enable;
   logic       csr_write_data;

   // Architecture codes still owed by the block, oldest first.
   logic [1:0] pending_arch_codes [$];
   logic [1:0] want_code;

   // The bytes of the section that is being built.
   logic [7:0] section_bytes [$];

   // Predictor state: our own copy of the byte order and the parse walk.
   logic           cfg_big_endian;
   walk_state_type walk;
   logic [63:0]    at_pos;
   logic [63:0]    sub_stop;
   logic [63:0]    blk_stop;
   logic [31:0]    len_acc;
   logic [2:0]     len_cnt;
   logic [31:0]    uleb_val;
   logic [5:0]     uleb_sh;
   logic [31:0]    tag_now;
   logic [1:0]     arch_now;
   logic           hard_fp;
   logic           bad_sect;

   // Coordination between the sender and the receiver.
   logic no_gaps;
   logic hold_rsp_req;
   logic rsp_holding;

   int error_count;
   int results_seen;
   int total_bytes;
   int parsed_bytes;
   int sections_sent;
   int stall_cycles;

   always #6 clock = ~clock;

   arm_build_attribute_classifier i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_arch_code    (rsp_arch_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // -------------------------------------------------------------------------
   // Predictor of the parser
   // -------------------------------------------------------------------------

   function automatic logic [7:0] aeabi_char(input int idx);
      return AEABI_TEXT[39 - 8 * idx -: 8];
   endfunction

   // Everything except the byte order goes back to its reset value.
   function automatic void restart_section();
      walk     = ST_VERSION;
      at_pos   = '0;
      sub_stop = '0;
      blk_stop = '0;
      len_acc  = '0;
      len_cnt  = '0;
      uleb_val = '0;
      uleb_sh  = '0;
      tag_now  = '0;
      arch_now = ARCH_NONE;
      hard_fp  = 1'b0;
      bad_sect = 1'b0;
   endfunction

   function automatic void mark_invalid();
      bad_sect = 1'b1;
      walk     = ST_FAILED;
   endfunction

   function automatic void take_length_byte(input logic [7:0] b);
      if (cfg_big_endian) begin
         len_acc = {len_acc[23:0], b};
      end else begin
         len_acc = len_acc | (32'(b) << (8 * len_cnt[1:0]));
      end
      len_cnt = len_cnt + 3'd1;
   endfunction

   // Adds one ULEB128 byte; returns 1 when the value is complete, which
   // includes the case where the attribute block runs out under it.
   function automatic bit uleb_byte(input logic [7:0] b, input logic [63:0] nxt);
      if (uleb_sh < 6'd32) begin
         uleb_val = uleb_val | 32'(64'(b[6:0]) << uleb_sh);
      end
      if (!b[7] || nxt >= blk_stop) begin
         return 1'b1;
      end
      uleb_sh = (int'(uleb_sh) + 7 > 63) ? 6'd63 : uleb_sh + 6'd7;
      return 1'b0;
   endfunction

   function automatic void close_subsection(input logic [63:0] nxt);
      if (nxt < sub_stop) begin
         walk = ST_SKIP;
      end else begin
         walk    = ST_SUB_LEN;
         len_acc = '0;
         len_cnt = '0;
      end
   endfunction

   function automatic void next_attribute(input logic [63:0] nxt);
      if (nxt < blk_stop) begin
         walk     = ST_ATTR_TAG;
         uleb_val = '0;
         uleb_sh  = '0;
      end else begin
         close_subsection(nxt);
      end
   endfunction

   function automatic void note_pair(input logic [31:0] tag, input logic [31:0] val);
      if (tag == TAG_PROC_ARCH) begin
         if (val == PROC_ARCH_V4) begin
            arch_now = ARCH_V4_SOFT;
         end else if (val == PROC_ARCH_V6) begin
            arch_now = ARCH_V6_HARD;
         end else if (val == PROC_ARCH_V7) begin
            arch_now = ARCH_V7_HARD;
         end else begin
            mark_invalid();
         end
      end else if (tag == TAG_VFP_ARGS && val == VFP_ARGS_HARD) begin
         hard_fp = 1'b1;
      end
   endfunction

   // The code reported on the last byte, with unsupported pairings cleared.
   function automatic logic [1:0] section_code();
      if (bad_sect) begin
         return ARCH_NONE;
      end
      if (arch_now == ARCH_V4_SOFT && hard_fp) begin
         return ARCH_NONE;
      end
      if ((arch_now == ARCH_V6_HARD || arch_now == ARCH_V7_HARD) && !hard_fp) begin
         return ARCH_NONE;
      end
      return arch_now;
   endfunction

   // Advances the predictor by one accepted byte. Returns 1 when that byte
   // produces a classification, which is then left in code.
   function automatic bit classify_byte(input logic [7:0] b, input logic last_flag,
                                        output logic [1:0] code);
      logic [63:0] here;
      logic [63:0] nxt;
      logic [63:0] grown;
      here  = at_pos & POS_LIMIT;
      nxt   = (here + 64'd1) & POS_LIMIT;
      code  = ARCH_NONE;
      case (walk)
         ST_VERSION: begin
            if (b == VERSION_BYTE) begin
               walk    = ST_SUB_LEN;
               len_acc = '0;
               len_cnt = '0;
            end else begin
               mark_invalid();
            end
         end
         ST_SUB_LEN: begin
            // The subsection length counts from its own first byte.
            if (len_cnt == 3'd0) begin
               sub_stop = here;
            end
            take_length_byte(b);
            if (len_cnt >= 3'd4) begin
               grown    = sub_stop + 64'(len_acc);
               sub_stop = (grown > POS_LIMIT) ? POS_LIMIT : grown;
               walk     = ST_VENDOR;
               len_cnt  = '0;
            end
         end
         ST_VENDOR: begin
            // The byte after the five name characters is taken as its end.
            if (len_cnt < VENDOR_LENGTH) begin
               if (b != aeabi_char(int'(len_cnt))) begin
                  close_subsection(nxt);
               end else begin
                  len_cnt = len_cnt + 3'd1;
               end
            end else begin
               walk = ST_FILE_TAG;
            end
         end
         ST_FILE_TAG: begin
            if (b != FILE_SCOPE_BYTE) begin
               close_subsection(nxt);
            end else begin
               blk_stop = here;
               len_acc  = '0;
               len_cnt  = '0;
               walk     = ST_ATTR_LEN;
            end
         end
         ST_ATTR_LEN: begin
            take_length_byte(b);
            if (len_cnt >= 3'd4) begin
               grown = blk_stop + 64'(len_acc);
               if (grown > sub_stop) begin
                  mark_invalid();
               end else begin
                  blk_stop = grown;
                  next_attribute(nxt);
               end
            end
         end
         ST_ATTR_TAG: begin
            if (uleb_byte(b, nxt)) begin
               tag_now = uleb_val;
               if (tag_now == TAG_CONFORMANCE || tag_now == TAG_CPU_NAME ||
                   tag_now == TAG_ALSO_COMPAT) begin
                  walk = ST_STRING;
               end else if (nxt >= blk_stop) begin
                  // The block ended right after the tag: its value is zero.
                  note_pair(tag_now, '0);
                  if (!bad_sect) begin
                     next_attribute(nxt);
                  end
               end else begin
                  walk     = ST_ATTR_VAL;
                  uleb_val = '0;
                  uleb_sh  = '0;
               end
            end
         end
         ST_STRING: begin
            if (b == 8'h00) begin
               if (nxt > blk_stop) begin
                  mark_invalid();
               end else begin
                  next_attribute(nxt);
               end
            end
         end
         ST_ATTR_VAL: begin
            if (uleb_byte(b, nxt)) begin
               note_pair(tag_now, uleb_val);
               if (!bad_sect) begin
                  next_attribute(nxt);
               end
            end
         end
         ST_SKIP: begin
            if (nxt >= sub_stop) begin
               close_subsection(nxt);
            end
         end
         default: begin
         end
      endcase
      at_pos = nxt;
      if (last_flag) begin
         code = section_code();
         restart_section();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // -------------------------------------------------------------------------
   // Section builders
   // -------------------------------------------------------------------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Adds one byte at the end of the section under construction.
   function automatic void append_byte(input logic [7:0] b);
      section_bytes = {section_bytes, b};
   endfunction

   // Writes a 4-byte length at a given offset, in the configured order or,
   // with swap set, in the other one.
   function automatic void patch_len(input int at, input logic [31:0] v, input bit swap);
      int i;
      for (i = 0; i < 4; i++) begin
         section_bytes[at + i] = (cfg_big_endian ^ swap) ? v[31 - 8 * i -: 8] : v[8 * i +: 8];
      end
   endfunction

   // ULEB128 encoding, optionally padded with redundant continuation bytes.
   function automatic void put_uleb(input logic [31:0] v, input int pad);
      logic [6:0] chunk;
      forever begin
         chunk = v[6:0];
         v     = v >> 7;
         if (v == '0 && pad == 0) begin
            append_byte({1'b0, chunk});
            break;
         end
         append_byte({1'b1, chunk});
         if (v == '0) pad--;
      end
   endfunction

   // A long ULEB128 with random content, reaching past bit 32 and, at its
   // longest, past the point where the shift count saturates.
   function automatic void put_wild_uleb();
      repeat ($urandom_range(5, 10)) append_byte({1'b1, 7'($urandom())});
      append_byte({1'b0, 7'($urandom())});
   endfunction

   function automatic void put_attribute();
      int r;
      int k;
      logic [31:0] val;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         put_uleb(TAG_PROC_ARCH, 0);
         k = $urandom_range(0, 9);
         val = (k < 3) ? PROC_ARCH_V4 : (k < 6) ? PROC_ARCH_V6 :
               (k < 9) ? PROC_ARCH_V7 : 32'($urandom_range(0, 300));
         put_uleb(val, ($urandom_range(0, 5) == 0) ? 1 : 0);
      end else if (r < 55) begin
         put_uleb(TAG_VFP_ARGS, 0);
         put_uleb(32'($urandom_range(0, 2)), 0);
      end else if (r < 70) begin
         k = $urandom_range(0, 2);
         put_uleb((k == 0) ? TAG_CONFORMANCE : (k == 1) ? TAG_CPU_NAME : TAG_ALSO_COMPAT, 0);
         repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(1, 255)));
         append_byte(8'h00);
      end else if (r < 90) begin
         put_uleb(32'($urandom_range(7, 200)), 0);
         put_uleb($urandom(), 0);
      end else begin
         put_uleb(32'($urandom_range(7, 27)), 0);
         put_wild_uleb();
      end
   endfunction

   function automatic void put_subsection();
      int at;
      int file_at;
      int r;
      int k;
      int i;
      logic [31:0] sub_len;
      logic [31:0] blk_len;
      at = section_bytes.size();
      repeat (4) append_byte(8'h00);
      r = $urandom_range(0, 99);
      if (r < 70) begin
         // The subsection that is parsed, with a random list of attributes.
         for (i = 0; i < 5; i++) append_byte(aeabi_char(i));
         append_byte(8'h00);
         file_at = section_bytes.size();
         append_byte(FILE_SCOPE_BYTE);
         repeat (4) append_byte(8'h00);
         repeat ($urandom_range(0, 5)) put_attribute();
         blk_len = 32'(section_bytes.size() - file_at);
         // Now and then the block length overshoots or cuts the attributes.
         k = $urandom_range(0, 19);
         if (k == 0) begin
            blk_len = blk_len + 32'($urandom_range(1, 4));
         end else if (k == 1) begin
            blk_len = 32'($urandom_range(0, blk_len));
         end
         patch_len(file_at + 1, blk_len, $urandom_range(0, 19) == 0);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) append_byte(8'($urandom()));
         end
      end else if (r < 80) begin
         // Some other vendor: its contents are skipped.
         repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(8'h61, 8'h7A)));
         append_byte(8'h00);
         repeat ($urandom_range(0, 8)) append_byte(8'($urandom()));
      end else if (r < 88) begin
         // The right vendor, but the first sub-block is not file scope.
         for (i = 0; i < 5; i++) append_byte(aeabi_char(i));
         append_byte(8'h00);
         do k = $urandom_range(0, 255); while (k == FILE_SCOPE_BYTE);
         append_byte(8'(k));
         repeat ($urandom_range(0, 8)) append_byte(8'($urandom()));
      end else begin
         // A vendor name that breaks off partway through "aeabi".
         k = $urandom_range(0, 4);
         for (i = 0; i < k; i++) append_byte(aeabi_char(i));
         append_byte(aeabi_char(k) ^ 8'h20);
         repeat ($urandom_range(0, 6)) append_byte(8'($urandom()));
      end
      // Mostly the true length; sometimes one that ends too early, one that
      // saturates the end position, or one written in the wrong byte order.
      sub_len = 32'(section_bytes.size() - at);
      k = $urandom_range(0, 29);
      if (k == 0) begin
         sub_len = 32'($urandom_range(0, 6));
      end else if (k == 1) begin
         sub_len = 32'hFFFF_FFFF;
      end
      patch_len(at, sub_len, k == 2);
   endfunction

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------

   // Offers one byte, waits for its transaction and then brings the
   // predictor along. Valid is left high so that the next call can follow
   // in the same step; whoever lets time pass afterwards lowers it first.
   task automatic push_byte(input logic [7:0] d, input logic last_flag,
                            input logic known, input logic [1:0] typed_code);
      int gap;
      logic [1:0] code;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last_flag;
      do @(posedge clock); while (!req_ready);
      total_bytes++;
      if (walk != ST_FAILED) parsed_bytes++;
      if (last_flag) sections_sent++;
      if (classify_byte(d, last_flag, code)) begin
         pending_arch_codes = {pending_arch_codes, known ? typed_code : code};
      end
   endtask

   initial begin
      int ph;
      int start_bytes;
      int n_sect;
      int k;
      int i;
      int r;
      logic order;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_last_byte    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      no_gaps          = 1'b0;
      hold_rsp_req     = 1'b0;
      error_count      = 0;
      results_seen     = 0;
      total_bytes      = 0;
      parsed_bytes     = 0;
      sections_sent    = 0;
      cfg_big_endian   = 1'b0;
      restart_section();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table, read with the byte order left little endian by reset.
      foreach (DIRECTED_ROWS[i]) begin
         push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last_flag,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].code);
      end

      // Random phases under big, little, big and then either byte order.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         // The register may change only while nothing is in flight. Every
         // section ends on its last byte, so once the last code has come
         // back the parser is idle; a few extra cycles cover the pipeline.
         req_valid <= 1'b0;
         while (pending_arch_codes.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         order = (ph == PHASE_COUNT - 1) ? 1'($urandom_range(0, 1)) : (ph % 2 == 0);
         csr_write_enable <= 1'b1;
         csr_write_data   <= order;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         cfg_big_endian    = order;

         start_bytes = parsed_bytes;
         n_sect      = 0;
         while (parsed_bytes - start_bytes < PHASE_BYTES || n_sect < PHASE_SECTIONS) begin
            if (ph == 1 && n_sect == 2) begin
               // Back pressure: the receiver holds off for a long stretch
               // while a run of one-byte sections is offered without gaps.
               // The single output register fills and the input stalls.
               req_valid    <= 1'b0;
               hold_rsp_req  = 1'b1;
               do @(posedge clock); while (!rsp_holding);
               no_gaps = 1'b1;
               for (k = 0; k < 12; k++) begin
                  push_byte((k % 2 == 0) ? VERSION_BYTE : 8'($urandom()), 1'b1, 1'b0, ARCH_NONE);
               end
               no_gaps = 1'b0;
            end

            section_bytes.delete();
            r = $urandom_range(0, 99);
            if (r < 8) begin
               repeat ($urandom_range(1, 12)) append_byte(8'($urandom()));
            end else begin
               append_byte(VERSION_BYTE);
               repeat ($urandom_range(1, 3)) put_subsection();
            end
            // Some sections end in the middle of whatever is being read.
            if ($urandom_range(0, 9) == 0) begin
               k = $urandom_range(1, section_bytes.size());
               while (section_bytes.size() > k) void'(section_bytes.pop_back());
            end

            // A quarter of the sections go out with no gaps at all.
            no_gaps = ($urandom_range(0, 3) == 0);
            for (i = 0; i < section_bytes.size(); i++) begin
               push_byte(section_bytes[i], i == section_bytes.size() - 1, 1'b0, ARCH_NONE);
            end
            no_gaps = 1'b0;
            n_sect++;
         end
      end

      // Wait for the remaining codes, then a little longer in case the
      // block produces something that nobody asked for.
      req_valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && pending_arch_codes.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_arch_codes.size() != 0) begin
         $display("%0t: %0d classifications never arrived", $time, pending_arch_codes.size());
         error_count += pending_arch_codes.size();
      end

      $display("Sent %0d sections in %0d bytes (%0d reached the parser) under both byte orders,",
               sections_sent, total_bytes, parsed_bytes);
      $display("with random idling and one long output stall; %0d codes checked, %0d errors.",
               results_seen, error_count);
      if (error_count == 0) begin
         $display("PASS arm_build_attribute_classifier");
      end else begin
         $display("FAIL arm_build_attribute_classifier");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver
   // -------------------------------------------------------------------------

   // Ready drops for random stretches, mostly short, and now and then stays
   // up for a long run. On request it holds off for a long counted stretch.
   initial begin
      int n;
      rsp_ready   = 1'b0;
      rsp_holding = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_holding  = 1'b1;
            rsp_ready   <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_holding  = 1'b0;
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(30, 80);
         repeat (n) @(posedge clock);
      end
   end

   // Each result transaction is compared with the oldest outstanding code.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_arch_codes.size() == 0) begin
            $display("%0t: unexpected result, arch_code %0d", $time, rsp_arch_code);
            error_count++;
         end else begin
            want_code = pending_arch_codes.pop_front();
            if (rsp_arch_code !== want_code) begin
               $display("%0t: arch_code mismatch, expected %0d, got %0d",
                        $time, want_code, rsp_arch_code);
               error_count++;
            end
         end
      end
   end

   // The run is stuck if no transaction happens on either channel for a
   // long time; the longest legal quiet stretch is the receiver hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL arm_build_attribute_classifier");
            $finish;
         end
      end
   end

endmodule
